// File: sv/bb3_pkg.sv
// Shared types, constants and a helper function for the 3x3 box blur.
`timescale 1ns / 1ps
package bb3_pkg;

  // Configuration register indexes
  localparam logic [0:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'd1;

  localparam int unsigned FW_BITS    = 11;
  localparam int unsigned FH_BITS    = 13;
  localparam int unsigned CFG_BITS   = 13;
  localparam logic [10:0] FW_RESET   = 11'd640;
  localparam logic [12:0] FH_RESET   = 13'd480;
  localparam int unsigned PIX_BITS   = 24;
  localparam int unsigned SUM_BITS   = 12;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        last_of_run;
  } pix_out_t;

  // Control from the sequencer to the window
  typedef struct packed {
    logic       shift;
    logic       load_sum;
    logic [2:0] row_mask;
    logic [2:0] col_mask;
  } win_ctrl_t;

  // Registered channel sums and tap count
  typedef struct packed {
    logic [SUM_BITS-1:0] sum_r;
    logic [SUM_BITS-1:0] sum_g;
    logic [SUM_BITS-1:0] sum_b;
    logic [3:0]          n;
  } sums_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SUM,
    ST_DIVIDE
  } state_t;

  // ceil(2^19 / (2n)) for each possible tap count
  function automatic logic [18:0] recip(input logic [3:0] n);
    logic [18:0] m;
    case (n)
      4'd2:    m = 19'd131072;
      4'd3:    m = 19'd87382;
      4'd4:    m = 19'd65536;
      4'd6:    m = 19'd43691;
      4'd9:    m = 19'd29128;
      default: m = 19'd262144;
    endcase
    return m;
  endfunction

endpackage

// File: sv/bb3_line_mem.sv
// Line store memory: upper and middle rows packed side by side per column.
`timescale 1ns / 1ps
module bb3_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [AW-1:0]                raddr,
  output logic [2*bb3_pkg::PIX_BITS-1:0] rdata,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [2*bb3_pkg::PIX_BITS-1:0] wdata
);

  logic [2*bb3_pkg::PIX_BITS-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/bb3_window.sv
// 3x3 pixel window with masked channel sums.
`timescale 1ns / 1ps
module bb3_window (
  input  logic                          clk,
  input  bb3_pkg::win_ctrl_t            ctrl,
  input  logic [bb3_pkg::PIX_BITS-1:0]  col_up,
  input  logic [bb3_pkg::PIX_BITS-1:0]  col_mid,
  input  logic [bb3_pkg::PIX_BITS-1:0]  col_new,
  output bb3_pkg::sums_t                sums
);

  logic [bb3_pkg::PIX_BITS-1:0] win [3][3];
  bb3_pkg::sums_t               sums_next;

  // Shift the window left and drop in the new column
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      for (int m = 0; m < 3; m++) begin
        win[m][0] <= win[m][1];
        win[m][1] <= win[m][2];
      end
      win[0][2] <= col_up;
      win[1][2] <= col_mid;
      win[2][2] <= col_new;
    end
  end

  // Add up the taps inside the frame
  always_comb begin
    sums_next = '0;
    for (int m = 0; m < 3; m++) begin
      for (int k = 0; k < 3; k++) begin
        if (ctrl.row_mask[m] && ctrl.col_mask[k]) begin
          sums_next.sum_r = sums_next.sum_r + bb3_pkg::SUM_BITS'(win[m][k][23:16]);
          sums_next.sum_g = sums_next.sum_g + bb3_pkg::SUM_BITS'(win[m][k][15:8]);
          sums_next.sum_b = sums_next.sum_b + bb3_pkg::SUM_BITS'(win[m][k][7:0]);
          sums_next.n     = sums_next.n + 4'd1;
        end
      end
    end
  end

  // Hold the sums for the divider
  always_ff @(posedge clk) begin
    if (ctrl.load_sum) begin
      sums <= sums_next;
    end
  end

endmodule

// File: sv/bb3_divide.sv
// Rounded mean: (2*sum + n) / (2n) by reciprocal multiplication.
`timescale 1ns / 1ps
module bb3_divide (
  input  bb3_pkg::sums_t sums,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue
);

  logic [18:0] m;
  logic [12:0] x_r, x_g, x_b;
  logic [31:0] p_r, p_g, p_b;

  // Scale each channel by the reciprocal of the divisor
  always_comb begin
    m   = bb3_pkg::recip(sums.n);
    x_r = {sums.sum_r, 1'b0} + 13'(sums.n);
    x_g = {sums.sum_g, 1'b0} + 13'(sums.n);
    x_b = {sums.sum_b, 1'b0} + 13'(sums.n);
    p_r = 32'(x_r) * 32'(m);
    p_g = 32'(x_g) * 32'(m);
    p_b = 32'(x_b) * 32'(m);
  end

  assign red   = p_r[26:19];
  assign green = p_g[26:19];
  assign blue  = p_b[26:19];

endmodule

// File: sv/box_blur_3x3_edge_aware_unit.sv
// Top level of the edge-aware 3x3 box blur.
//
//  Channel  Signals                         Role
//  in       in_valid/in_ready/in_data       raster RGB pixels
//  out      out_valid/out_ready/out_data    blurred pixels with row, column, last flag
//  cfg      cfg_we/cfg_index/cfg_data       frame width (0), frame height (1)
//
// An input passes through a line store read, then write-back and window shift,
// and each result it emits through a sum, then a divide into the output
// register; the divide step holds while the output register is still full.
// The line store read is registered, and all results share one sum/divide
// path, so no new input is taken until every result has been emitted.
// Reset clears the position counters and the handshake state and sets the
// sizes to 640 by 480; the line store needs no clearing.
`timescale 1ns / 1ps
module box_blur_3x3_edge_aware_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bb3_pkg::pix_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bb3_pkg::pix_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [bb3_pkg::CFG_BITS-1:0]  cfg_data
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [bb3_pkg::FW_BITS-1:0] frame_width;
  logic [bb3_pkg::FH_BITS-1:0] frame_height;
  logic [CW:0]                 w_eff;
  logic [RW:0]                 h_eff;

  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic [CW-1:0] cur_c, c_wrap;
  logic [RW-1:0] cur_r, r_wrap;
  logic [RW:0]   r_inc;
  logic [3:0]    plan, plan_next;
  logic [bb3_pkg::PIX_BITS-1:0] px;

  bb3_pkg::state_t state, state_next;
  logic accept, mem_we, out_load, pick_last;
  logic pick_up, pick_left;
  logic [1:0] pick_idx;
  logic [3:0] pick_bit;
  logic [RW-1:0] res_r;
  logic [CW-1:0] res_c;
  logic          res_last;
  logic [31:0]   res_r32, res_c32;

  logic [2*bb3_pkg::PIX_BITS-1:0] rdata;
  bb3_pkg::win_ctrl_t ctrl;
  bb3_pkg::sums_t     sums;
  logic [7:0]         q_r, q_g, q_b;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::FW_RESET;
      frame_height <= bb3_pkg::FH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bb3_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[bb3_pkg::FW_BITS-1:0];
        bb3_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[bb3_pkg::FH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the sizes to 1..max
  always_comb begin
    if (frame_width == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = (RW+1)'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(frame_height);
    end
  end

  assign accept = in_valid && in_ready;

  // Wrap the position, plan the results and advance the counters
  always_comb begin
    if ({1'b0, col} >= w_eff) begin
      c_wrap = '0;
      r_inc  = {1'b0, row} + (RW+1)'(1);
    end else begin
      c_wrap = col;
      r_inc  = {1'b0, row};
    end
    r_wrap = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];

    plan_next[0] = (r_wrap != '0) && (c_wrap != '0);
    plan_next[1] = (r_wrap != '0) && (({1'b0, c_wrap} + (CW+1)'(1)) == w_eff);
    plan_next[2] = (({1'b0, r_wrap} + (RW+1)'(1)) == h_eff) && (c_wrap != '0);
    plan_next[3] = (({1'b0, r_wrap} + (RW+1)'(1)) == h_eff)
                && (({1'b0, c_wrap} + (CW+1)'(1)) == w_eff);

    if (({1'b0, c_wrap} + (CW+1)'(1)) >= w_eff) begin
      col_next = '0;
      row_next = (({1'b0, r_wrap} + (RW+1)'(1)) >= h_eff) ? '0 : r_wrap + RW'(1);
    end else begin
      col_next = c_wrap + CW'(1);
      row_next = r_wrap;
    end
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Latch the accepted pixel and its position
  always_ff @(posedge clk) begin
    if (accept) begin
      px    <= {in_data.red_in, in_data.green_in, in_data.blue_in};
      cur_c <= c_wrap;
      cur_r <= r_wrap;
    end
  end

  // Pick the next pending result, lowest first
  always_comb begin
    pick_idx = 2'd3;
    for (int i = 3; i >= 0; i--) begin
      if (plan[i]) begin
        pick_idx = 2'(i);
      end
    end
    pick_bit  = 4'b0001 << pick_idx;
    pick_up   = !pick_idx[1];
    pick_left = !pick_idx[0];
    pick_last = (plan & ~pick_bit) == '0;
  end

  // Pending result list
  always_ff @(posedge clk) begin
    if (rst) begin
      plan <= '0;
    end else if (accept) begin
      plan <= plan_next;
    end else if (out_load) begin
      plan <= plan & ~pick_bit;
    end
  end

  // Position of the result being built
  always_ff @(posedge clk) begin
    if (ctrl.load_sum) begin
      res_r    <= pick_up ? cur_r - RW'(1) : cur_r;
      res_c    <= pick_left ? cur_c - CW'(1) : cur_c;
      res_last <= pick_last;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bb3_pkg::ST_IDLE:   if (accept) state_next = bb3_pkg::ST_UPDATE;
      bb3_pkg::ST_UPDATE: state_next = (plan == '0) ? bb3_pkg::ST_IDLE : bb3_pkg::ST_SUM;
      bb3_pkg::ST_SUM:    state_next = bb3_pkg::ST_DIVIDE;
      bb3_pkg::ST_DIVIDE: begin
        if (out_load) begin
          state_next = res_last ? bb3_pkg::ST_IDLE : bb3_pkg::ST_SUM;
        end
      end
      default: state_next = bb3_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bb3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // State outputs
  always_comb begin
    in_ready      = (state == bb3_pkg::ST_IDLE);
    mem_we        = (state == bb3_pkg::ST_UPDATE);
    ctrl.shift    = (state == bb3_pkg::ST_UPDATE);
    ctrl.load_sum = (state == bb3_pkg::ST_SUM);
    ctrl.row_mask = {1'b1, cur_r != '0, pick_up && (cur_r > RW'(1))};
    ctrl.col_mask = {1'b1, cur_c != '0, pick_left && (cur_c > CW'(1))};
    out_load      = (state == bb3_pkg::ST_DIVIDE) && (!out_valid || out_ready);
  end

  bb3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk   (clk),
    .rd_en (accept),
    .raddr (c_wrap),
    .rdata (rdata),
    .we    (mem_we),
    .waddr (cur_c),
    .wdata ({rdata[bb3_pkg::PIX_BITS-1:0], px})
  );

  bb3_window u_window (
    .clk     (clk),
    .ctrl    (ctrl),
    .col_up  (rdata[2*bb3_pkg::PIX_BITS-1:bb3_pkg::PIX_BITS]),
    .col_mid (rdata[bb3_pkg::PIX_BITS-1:0]),
    .col_new (px),
    .sums    (sums)
  );

  bb3_divide u_divide (
    .sums  (sums),
    .red   (q_r),
    .green (q_g),
    .blue  (q_b)
  );

  assign res_r32 = 32'(res_r);
  assign res_c32 = 32'(res_c);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.red_out     <= q_r;
      out_data.green_out   <= q_g;
      out_data.blue_out    <= q_b;
      out_data.out_row     <= res_r32[11:0];
      out_data.out_col     <= res_c32[9:0];
      out_data.last_of_run <= res_last;
    end
  end

endmodule
